### rtl/chs_pkg.sv
// Package for the chained hash set: key width, command and status codes,
// default sizes and the controller state type. No dependencies.

package chs_pkg;

  localparam int KeyW          = 32;
  localparam int BucketOutW    = 3;
  localparam int BucketsDef    = 7;
  localparam int PoolNodesDef  = 64;

  // Remainder unit: key bits folded in per cycle and fold steps per key.
  localparam int ModBits       = 4;
  localparam int ModSteps      = KeyW / ModBits;
  localparam int ModCntW       = $clog2(ModSteps);

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_SEARCH  = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_FIX,
    ST_BREAD,
    ST_BDATA,
    ST_LINK,
    ST_WALK
  } state_e;

endpackage

### rtl/chained_hash_set_top.sv
// Chained hash set controller: bucket remainder unit, bucket table memory,
// node pool memory and the walk sequencer. Depends on chs_pkg.

// A command (insert or search of a signed 32-bit key) is transferred at a
// clock edge where start_i is high and busy_o is low. Exactly one result
// follows, shown for a single cycle while done_o is high; the receiver
// cannot hold it off, so it must capture found_o, bucket_o and status_o in
// that cycle. The bucket is the key modulo BUCKETS, moved into range for
// negative keys, found with a shift-subtract remainder unit that folds in
// four key bits per cycle. The bucket table keeps a head and a tail node
// index per bucket, so an insert never walks its chain: into an empty
// bucket it writes the new node and the bucket entry at once; otherwise it
// also reads the old tail node and rewrites that node's link. An insert
// that finds the pool full is refused before the bucket table is read. A
// search reads one chain node per cycle from the node memory until a match
// or the chain's end, and none for an empty bucket. The next command can be
// transferred in the same cycle in which done_o is high. There is no
// clearing pass after reset: bucket emptiness lives in per-bucket flags,
// and node entries are only read once they have been written.

module chained_hash_set_top #(
  parameter int BUCKETS    = chs_pkg::BucketsDef,
  parameter int POOL_NODES = chs_pkg::PoolNodesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            command_i,
  input  logic signed [chs_pkg::KeyW-1:0] key_i,
  output logic                            done_o,
  output logic                            found_o,
  output logic [chs_pkg::BucketOutW-1:0]  bucket_o,
  output logic                            status_o
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;  // bucket index width
  localparam int RW = BW + 1;                                // remainder work width
  localparam int NW = $clog2(POOL_NODES);                    // node index width
  localparam int CW = $clog2(POOL_NODES + 1);                // node count width
  localparam int KW = chs_pkg::KeyW;
  localparam int MB = chs_pkg::ModBits;

  typedef struct packed {
    logic [NW-1:0] head;
    logic [NW-1:0] tail;
  } bentry_t;

  typedef struct packed {
    logic [KW-1:0] key;
    logic [NW-1:0] link;
  } node_t;

  // Controller state.
  chs_pkg::state_e              state_q, state_d;
  logic [chs_pkg::ModCntW-1:0]  cnt_q, cnt_d;
  logic                         cmd_q, cmd_d;
  logic [KW-1:0]                key_q, key_d;
  logic [KW-1:0]                mag_q, mag_d;
  logic                         neg_q, neg_d;
  logic [RW-1:0]                rem_q, rem_d;
  logic [BW-1:0]                bkt_q, bkt_d;
  logic [NW-1:0]                idx_q, idx_d;
  logic [NW-1:0]                tail_q, tail_d;
  logic [CW-1:0]                used_q, used_d;
  logic [BUCKETS-1:0]           hvalid_q, hvalid_d;
  logic                         done_q, done_d;
  logic                         found_q, found_d;
  logic                         status_q, status_d;

  // Memories and their ports.
  bentry_t                      bucket_mem [BUCKETS];
  node_t                        node_mem   [POOL_NODES];
  bentry_t                      bm_rdata_q;
  node_t                        nm_rdata_q;
  logic                         bm_we;
  bentry_t                      bm_wdata;
  logic                         nm_we;
  logic [NW-1:0]                nm_waddr;
  node_t                        nm_wdata;
  logic [NW-1:0]                nm_raddr;

  logic                         accept;
  logic                         pool_full;
  logic [NW-1:0]                fresh;

  assign accept    = start_i && !busy_o;
  assign pool_full = (used_q == CW'(POOL_NODES));
  assign fresh     = used_q[NW-1:0];

  assign busy_o    = (state_q != chs_pkg::ST_IDLE);
  assign done_o    = done_q;
  assign found_o   = found_q;
  assign status_o  = status_q;
  assign bucket_o  = chs_pkg::BucketOutW'(bkt_q);

  // The bucket table is always read at the current bucket; the node memory
  // at whatever address the sequencer asks for. Both reads are registered.
  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      bucket_mem[bkt_q] <= bm_wdata;
    end
    if (nm_we) begin
      node_mem[nm_waddr] <= nm_wdata;
    end
    bm_rdata_q <= bucket_mem[bkt_q];
    nm_rdata_q <= node_mem[nm_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= chs_pkg::ST_IDLE;
      cnt_q    <= '0;
      used_q   <= '0;
      hvalid_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      used_q   <= used_d;
      hvalid_q <= hvalid_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    mag_q    <= mag_d;
    neg_q    <= neg_d;
    rem_q    <= rem_d;
    bkt_q    <= bkt_d;
    idx_q    <= idx_d;
    tail_q   <= tail_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  always_comb begin
    logic [RW-1:0] r;
    state_d  = state_q;
    cnt_d    = cnt_q;
    cmd_d    = cmd_q;
    key_d    = key_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    rem_d    = rem_q;
    bkt_d    = bkt_q;
    idx_d    = idx_q;
    tail_d   = tail_q;
    used_d   = used_q;
    hvalid_d = hvalid_q;
    done_d   = 1'b0;
    found_d  = found_q;
    status_d = status_q;
    bm_we    = 1'b0;
    bm_wdata = bm_rdata_q;
    nm_we    = 1'b0;
    nm_waddr = fresh;
    nm_wdata = '{key: key_q, link: '0};
    nm_raddr = idx_q;
    r        = rem_q;

    case (state_q)
      chs_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_d   = command_i;
          key_d   = key_i;
          neg_d   = key_i[KW-1];
          mag_d   = key_i[KW-1] ? (~key_i + KW'(1)) : key_i;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = chs_pkg::ST_MOD;
        end
      end

      chs_pkg::ST_MOD: begin
        // Fold the next magnitude bits into the remainder, most significant first.
        for (int i = 0; i < MB; i++) begin
          r = {r[BW-1:0], mag_q[KW-1-i]};
          if (r >= RW'(BUCKETS)) begin
            r = r - RW'(BUCKETS);
          end
        end
        rem_d = r;
        mag_d = mag_q << MB;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == chs_pkg::ModCntW'(chs_pkg::ModSteps - 1)) begin
          state_d = chs_pkg::ST_FIX;
        end
      end

      chs_pkg::ST_FIX: begin
        if (neg_q && (rem_q != '0)) begin
          bkt_d = BW'(RW'(BUCKETS) - rem_q);
        end else begin
          bkt_d = BW'(rem_q);
        end
        if ((cmd_q == chs_pkg::CMD_INSERT) && pool_full) begin
          found_d  = 1'b0;
          status_d = chs_pkg::STATUS_FULL;
          done_d   = 1'b1;
          state_d  = chs_pkg::ST_IDLE;
        end else begin
          state_d = chs_pkg::ST_BREAD;
        end
      end

      chs_pkg::ST_BREAD: begin
        // The bucket entry read is in flight this cycle.
        state_d = chs_pkg::ST_BDATA;
      end

      chs_pkg::ST_BDATA: begin
        found_d  = 1'b0;
        status_d = chs_pkg::STATUS_DONE;
        if (cmd_q == chs_pkg::CMD_INSERT) begin
          nm_we    = 1'b1;
          nm_waddr = fresh;
          nm_wdata = '{key: key_q, link: '0};
          used_d   = used_q + 1'b1;
          bm_we    = 1'b1;
          if (!hvalid_q[bkt_q]) begin
            bm_wdata         = '{head: fresh, tail: fresh};
            hvalid_d[bkt_q]  = 1'b1;
            done_d           = 1'b1;
            state_d          = chs_pkg::ST_IDLE;
          end else begin
            // Fetch the old tail so its link can be rewritten next cycle.
            bm_wdata = '{head: bm_rdata_q.head, tail: fresh};
            nm_raddr = bm_rdata_q.tail;
            tail_d   = bm_rdata_q.tail;
            idx_d    = fresh;
            state_d  = chs_pkg::ST_LINK;
          end
        end else begin
          if (!hvalid_q[bkt_q]) begin
            done_d  = 1'b1;
            state_d = chs_pkg::ST_IDLE;
          end else begin
            nm_raddr = bm_rdata_q.head;
            idx_d    = bm_rdata_q.head;
            tail_d   = bm_rdata_q.tail;
            state_d  = chs_pkg::ST_WALK;
          end
        end
      end

      chs_pkg::ST_LINK: begin
        nm_we    = 1'b1;
        nm_waddr = tail_q;
        nm_wdata = '{key: nm_rdata_q.key, link: idx_q};
        done_d   = 1'b1;
        state_d  = chs_pkg::ST_IDLE;
      end

      chs_pkg::ST_WALK: begin
        if (nm_rdata_q.key == key_q) begin
          found_d = 1'b1;
          done_d  = 1'b1;
          state_d = chs_pkg::ST_IDLE;
        end else if (idx_q == tail_q) begin
          found_d = 1'b0;
          done_d  = 1'b1;
          state_d = chs_pkg::ST_IDLE;
        end else begin
          nm_raddr = nm_rdata_q.link;
          idx_d    = nm_rdata_q.link;
        end
      end

      default: begin
        state_d = chs_pkg::ST_IDLE;
      end
    endcase
  end

  // The node count never runs past the pool size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(POOL_NODES))
    else $error("node count exceeds pool size");

  // A walk only visits nodes that have been handed out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == chs_pkg::ST_WALK) |-> (CW'(idx_q) < used_q))
    else $error("chain walk reached an unallocated node");

  // A refused insert never reports a match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> !found_o)
    else $error("pool-full result carries found");

  // A result is only shown once the sequencer has gone back to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // The pool only grows by one node, and only from the bucket-data step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |->
      ((used_q == $past(used_q) + 1'b1) && ($past(state_q) == chs_pkg::ST_BDATA)))
    else $error("unexpected node count change");

endmodule
